[rtl/gbn_pkg.sv]
package gbn_pkg;

   // sizing limits
   localparam int MAX_WINDOW  = 32;
   localparam int MAX_MESSAGE = 4096;
   localparam int MAX_CHUNK   = 100;

   // fixed field widths
   localparam int OPCODE_W   = 2;
   localparam int KIND_W     = 8;
   localparam int ACK_W      = 12;
   localparam int CMD_W      = 2;
   localparam int PKT_SEQ_W  = 12;
   localparam int CHUNK_W    = 7;
   localparam int RETRY_W    = 8;
   localparam int TIMEOUT_W  = 16;
   localparam int WIN_REG_W  = 6;
   localparam int MSG_REG_W  = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // derived widths
   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int SEQ_W = $clog2(MAX_MESSAGE + 1);
   localparam int NUM_W = $clog2(MAX_MESSAGE + MAX_CHUNK);

   // request queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ACK   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

   localparam logic [KIND_W-1:0] VALID_ACK = 8'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MESSAGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RETRY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 3'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_SEND     = 2'd0,
      CMD_TEARDOWN = 2'd1,
      CMD_GIVE_UP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_ACK   = 2'd1,
      EV_TICK  = 2'd2
   } ev_type;

   typedef struct packed {
      ev_type           ev;
      logic [ACK_W-1:0] ack_number;
   } ev_entry_type;

   // clamped configuration seen by the back end
   typedef struct packed {
      logic [WIN_W-1:0]     win;
      logic [SEQ_W-1:0]     msg;
      logic [CHUNK_W-1:0]   chunk;
      logic [RETRY_W-1:0]   retry;
      logic [TIMEOUT_W-1:0] timeout;
   } cfg_type;

endpackage

[rtl/go_back_n_sender_unit.sv]
// Go-Back-N sender window control. Requests (start, acknowledgement, tick) enter a
// two-entry queue and are taken by the sequencer one at a time: each is dequeued, then
// decided, and the commands it produces are then issued one by one as the output
// register frees; that register lets the next request be queued while a command
// waits to be taken. After reset and after every configuration write the packet
// count is recomputed by a bit-serial divider; requests are still queued meanwhile
// but the sequencer holds them until the count is ready. Out-of-range register values
// are clamped (window 1..32, message 1..4096, chunk 1..100, retry limit and timeout
// at least 1).
module go_back_n_sender_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gbn_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [gbn_pkg::KIND_W-1:0]     req_ack_kind,
   input  logic [gbn_pkg::ACK_W-1:0]      req_ack_number,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gbn_pkg::CMD_W-1:0]      rsp_command,
   output logic [gbn_pkg::PKT_SEQ_W-1:0]  rsp_packet_seq,
   output logic [gbn_pkg::CHUNK_W-1:0]    rsp_packet_length,
   output logic                           rsp_final_res,
   input  logic                           csr_we,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [gbn_pkg::WIN_REG_W-1:0] win_ff;
   logic [gbn_pkg::MSG_REG_W-1:0] msg_ff;
   logic [gbn_pkg::CHUNK_W-1:0]   chunk_ff;
   logic [gbn_pkg::RETRY_W-1:0]   retry_ff;
   logic [gbn_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic                          recalc_ff, recalc_in;

   gbn_pkg::cfg_type              cfg;
   logic                          div_start;
   logic                          div_busy;
   logic [gbn_pkg::NUM_W-1:0]     div_numer;
   logic [gbn_pkg::NUM_W-1:0]     div_quot;
   logic [gbn_pkg::SEQ_W-1:0]     pkt_count;
   logic                          hold;

   logic                          q_valid;
   gbn_pkg::ev_entry_type         q_entry;
   logic                          q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= gbn_pkg::WIN_REG_W'(4);
         msg_ff     <= gbn_pkg::MSG_REG_W'(100);
         chunk_ff   <= gbn_pkg::CHUNK_W'(10);
         retry_ff   <= gbn_pkg::RETRY_W'(10);
         timeout_ff <= gbn_pkg::TIMEOUT_W'(3000);
      end else if (csr_we) begin
         unique case (csr_index)
            gbn_pkg::REG_WINDOW:  win_ff     <= csr_wdata[gbn_pkg::WIN_REG_W-1:0];
            gbn_pkg::REG_MESSAGE: msg_ff     <= csr_wdata[gbn_pkg::MSG_REG_W-1:0];
            gbn_pkg::REG_CHUNK:   chunk_ff   <= csr_wdata[gbn_pkg::CHUNK_W-1:0];
            gbn_pkg::REG_RETRY:   retry_ff   <= csr_wdata[gbn_pkg::RETRY_W-1:0];
            gbn_pkg::REG_TIMEOUT: timeout_ff <= csr_wdata[gbn_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp to the supported ranges
   always_comb begin
      if (win_ff == '0) begin
         cfg.win = gbn_pkg::WIN_W'(1);
      end else if (int'(win_ff) > gbn_pkg::MAX_WINDOW) begin
         cfg.win = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
      end else begin
         cfg.win = gbn_pkg::WIN_W'(win_ff);
      end
      if (msg_ff == '0) begin
         cfg.msg = gbn_pkg::SEQ_W'(1);
      end else if (int'(msg_ff) > gbn_pkg::MAX_MESSAGE) begin
         cfg.msg = gbn_pkg::SEQ_W'(gbn_pkg::MAX_MESSAGE);
      end else begin
         cfg.msg = gbn_pkg::SEQ_W'(msg_ff);
      end
      if (chunk_ff == '0) begin
         cfg.chunk = gbn_pkg::CHUNK_W'(1);
      end else if (int'(chunk_ff) > gbn_pkg::MAX_CHUNK) begin
         cfg.chunk = gbn_pkg::CHUNK_W'(gbn_pkg::MAX_CHUNK);
      end else begin
         cfg.chunk = chunk_ff;
      end
      cfg.retry   = (retry_ff == '0) ? gbn_pkg::RETRY_W'(1) : retry_ff;
      cfg.timeout = (timeout_ff == '0) ? gbn_pkg::TIMEOUT_W'(1) : timeout_ff;
   end

   // packet count recalculation after reset and every write
   assign div_start = recalc_ff && !div_busy;
   assign recalc_in = csr_we || (recalc_ff && !div_start);
   assign hold      = recalc_ff || div_busy;
   assign div_numer = gbn_pkg::NUM_W'(cfg.msg) + gbn_pkg::NUM_W'(cfg.chunk) - 1'b1;
   assign pkt_count = gbn_pkg::SEQ_W'(div_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         recalc_ff <= 1'b1;
      end else begin
         recalc_ff <= recalc_in;
      end
   end

   gbn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (cfg.chunk),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   gbn_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_ack_kind   (req_ack_kind),
      .req_ack_number (req_ack_number),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   gbn_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .pkt_count         (pkt_count),
      .hold              (hold),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command       (rsp_command),
      .rsp_packet_seq    (rsp_packet_seq),
      .rsp_packet_length (rsp_packet_length),
      .rsp_final_res     (rsp_final_res)
   );

endmodule

[rtl/gbn_div.sv]
module gbn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gbn_pkg::NUM_W-1:0]   numer,
   input  logic [gbn_pkg::CHUNK_W-1:0] denom,
   output logic                        busy,
   output logic [gbn_pkg::NUM_W-1:0]   quot
);

   localparam int CNT_W = $clog2(gbn_pkg::NUM_W + 1);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [gbn_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [gbn_pkg::CHUNK_W-1:0] rem_ff, rem_in;
   logic [gbn_pkg::CHUNK_W-1:0] den_ff, den_in;
   logic [gbn_pkg::CHUNK_W:0]   trial;
   logic [gbn_pkg::CHUNK_W:0]   diff;
   logic                        ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, num_ff[gbn_pkg::NUM_W-1]};
      ge    = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         num_in   = {num_ff[gbn_pkg::NUM_W-2:0], ge};
         rem_in   = ge ? diff[gbn_pkg::CHUNK_W-1:0] : trial[gbn_pkg::CHUNK_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(gbn_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

[rtl/gbn_front.sv]
module gbn_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gbn_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [gbn_pkg::KIND_W-1:0]   req_ack_kind,
   input  logic [gbn_pkg::ACK_W-1:0]    req_ack_number,
   output logic                         q_valid,
   output gbn_pkg::ev_entry_type        q_entry,
   input  logic                         q_pop
);

   gbn_pkg::ev_entry_type           entry_ff [gbn_pkg::QUEUE_DEPTH];
   logic [gbn_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gbn_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gbn_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            keep;
   logic                            push;
   gbn_pkg::ev_entry_type           new_entry;

   // classify the request: unknown opcodes and foreign ack kinds are dropped
   always_comb begin
      keep               = 1'b0;
      new_entry.ev       = gbn_pkg::EV_START;
      new_entry.ack_number = req_ack_number;
      unique case (req_opcode)
         gbn_pkg::OP_START: begin
            keep         = 1'b1;
            new_entry.ev = gbn_pkg::EV_START;
         end
         gbn_pkg::OP_ACK: begin
            keep         = (req_ack_kind == gbn_pkg::VALID_ACK);
            new_entry.ev = gbn_pkg::EV_ACK;
         end
         gbn_pkg::OP_TICK: begin
            keep         = 1'b1;
            new_entry.ev = gbn_pkg::EV_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gbn_pkg::QPTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == gbn_pkg::QPTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

[rtl/gbn_back.sv]
module gbn_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gbn_pkg::cfg_type              cfg,
   input  logic [gbn_pkg::SEQ_W-1:0]     pkt_count,
   input  logic                          hold,
   input  logic                          q_valid,
   input  gbn_pkg::ev_entry_type         q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbn_pkg::CMD_W-1:0]     rsp_command,
   output logic [gbn_pkg::PKT_SEQ_W-1:0] rsp_packet_seq,
   output logic [gbn_pkg::CHUNK_W-1:0]   rsp_packet_length,
   output logic                          rsp_final_res
);

   localparam int PROD_W = gbn_pkg::SEQ_W + gbn_pkg::CHUNK_W;

   typedef enum logic [3:0] {
      ST_WAIT   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_SINGLE = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   gbn_pkg::ev_type                ev_ff, ev_in;
   logic [gbn_pkg::ACK_W-1:0]      ack_ff, ack_in;
   logic                           running_ff, running_in;
   logic [gbn_pkg::SEQ_W-1:0]      base_ff, base_in;
   logic [gbn_pkg::SEQ_W-1:0]      next_ff, next_in;
   logic [gbn_pkg::RETRY_W-1:0]    try_ff, try_in;
   logic [gbn_pkg::TIMEOUT_W-1:0]  tick_ff, tick_in;
   gbn_pkg::cmd_type               single_ff, single_in;

   logic                           out_valid_ff, out_valid_in;
   gbn_pkg::cmd_type               out_cmd_ff, out_cmd_in;
   logic [gbn_pkg::PKT_SEQ_W-1:0]  out_seq_ff, out_seq_in;
   logic [gbn_pkg::CHUNK_W-1:0]    out_len_ff, out_len_in;
   logic                           out_final_ff, out_final_in;

   logic                           slot_free;
   logic [gbn_pkg::ACK_W:0]        ack_plus;
   logic [gbn_pkg::SEQ_W:0]        win_end;
   logic [gbn_pkg::SEQ_W-1:0]      lim;
   logic [gbn_pkg::SEQ_W:0]        next_plus;
   logic                           emit_more;
   logic                           last_send;
   logic [PROD_W-1:0]              start_byte;
   logic [PROD_W-1:0]              remaining;
   logic [gbn_pkg::CHUNK_W-1:0]    send_len;
   logic [gbn_pkg::TIMEOUT_W:0]    tick_plus;
   logic [gbn_pkg::RETRY_W:0]      try_plus;
   logic                           ack_in_window;

   // window limit and length of the next send
   always_comb begin
      ack_plus      = {1'b0, ack_ff} + 1'b1;
      ack_in_window = (int'(ack_ff) >= int'(base_ff)) && (int'(ack_ff) < int'(next_ff));
      win_end       = {1'b0, base_ff} + (gbn_pkg::SEQ_W + 1)'(cfg.win);
      lim           = (win_end > {1'b0, pkt_count}) ? pkt_count
                                                    : win_end[gbn_pkg::SEQ_W-1:0];
      next_plus     = {1'b0, next_ff} + 1'b1;
      emit_more     = (next_ff < lim);
      last_send     = (next_plus >= {1'b0, lim});
      start_byte    = PROD_W'(next_ff) * PROD_W'(cfg.chunk);
      remaining     = PROD_W'(cfg.msg) - start_byte;
      send_len      = (remaining >= PROD_W'(cfg.chunk)) ? cfg.chunk
                                                        : remaining[gbn_pkg::CHUNK_W-1:0];
      tick_plus     = {1'b0, tick_ff} + 1'b1;
      try_plus      = {1'b0, try_ff} + 1'b1;
   end

   assign slot_free = !out_valid_ff || rsp_ready;

   // event sequencer
   always_comb begin
      state_in     = state_ff;
      ev_in        = ev_ff;
      ack_in       = ack_ff;
      running_in   = running_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      try_in       = try_ff;
      tick_in      = tick_ff;
      single_in    = single_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cmd_in   = out_cmd_ff;
      out_seq_in   = out_seq_ff;
      out_len_in   = out_len_ff;
      out_final_in = out_final_ff;

      unique case (state_ff)
         ST_WAIT: begin
            if (q_valid && !hold) begin
               q_pop    = 1'b1;
               ev_in    = q_entry.ev;
               ack_in   = q_entry.ack_number;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_WAIT;
            unique case (ev_ff)
               gbn_pkg::EV_START: begin
                  if (!running_ff) begin
                     running_in = 1'b1;
                     base_in    = '0;
                     next_in    = '0;
                     try_in     = '0;
                     tick_in    = '0;
                     state_in   = ST_EMIT;
                  end
               end
               gbn_pkg::EV_ACK: begin
                  if (running_ff && ack_in_window) begin
                     base_in = gbn_pkg::SEQ_W'(ack_plus);
                     try_in  = '0;
                     tick_in = '0;
                     if (int'(ack_plus) >= int'(pkt_count)) begin
                        running_in = 1'b0;
                        single_in  = gbn_pkg::CMD_TEARDOWN;
                        state_in   = ST_SINGLE;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
               end
               gbn_pkg::EV_TICK: begin
                  if (running_ff) begin
                     if (tick_plus < {1'b0, cfg.timeout}) begin
                        tick_in = tick_plus[gbn_pkg::TIMEOUT_W-1:0];
                     end else begin
                        tick_in = '0;
                        try_in  = try_plus[gbn_pkg::RETRY_W-1:0];
                        if (try_plus >= {1'b0, cfg.retry}) begin
                           running_in = 1'b0;
                           single_in  = gbn_pkg::CMD_GIVE_UP;
                           state_in   = ST_SINGLE;
                        end else begin
                           next_in  = base_ff;
                           state_in = ST_EMIT;
                        end
                     end
                  end
               end
               default: state_in = ST_WAIT;
            endcase
         end
         ST_EMIT: begin
            // one send command per cycle while the window allows and the output slot is free
            if (!emit_more) begin
               state_in = ST_WAIT;
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_cmd_in   = gbn_pkg::CMD_SEND;
               out_seq_in   = gbn_pkg::PKT_SEQ_W'(next_ff);
               out_len_in   = send_len;
               out_final_in = last_send;
               next_in      = next_plus[gbn_pkg::SEQ_W-1:0];
               if (last_send) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_SINGLE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_cmd_in   = single_ff;
               out_seq_in   = '0;
               out_len_in   = '0;
               out_final_in = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         running_ff   <= 1'b0;
         base_ff      <= '0;
         next_ff      <= '0;
         try_ff       <= '0;
         tick_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         try_ff       <= try_in;
         tick_ff      <= tick_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_ff        <= ev_in;
      ack_ff       <= ack_in;
      single_ff    <= single_in;
      out_cmd_ff   <= out_cmd_in;
      out_seq_ff   <= out_seq_in;
      out_len_ff   <= out_len_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_command       = out_cmd_ff;
   assign rsp_packet_seq    = out_seq_ff;
   assign rsp_packet_length = out_len_ff;
   assign rsp_final_res     = out_final_ff;

endmodule
